// ----- src/btda_pkg.sv -----
package btda_pkg;

    localparam int VALUE_BITS = 32;
    localparam int PORT_BITS  = 32;
    localparam int IN_BITS    = (VALUE_BITS < PORT_BITS) ? VALUE_BITS : PORT_BITS;
    localparam int DIGITS     = ((IN_BITS * 1233) >> 12) + 1;
    localparam int BCD_BITS   = DIGITS * 4;
    localparam int BIT_CNT_W  = $clog2(IN_BITS);
    localparam int DIG_CNT_W  = $clog2(DIGITS);
    localparam int CHAR_W     = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
    localparam logic [3:0]        DABBLE_MIN = 4'd5;
    localparam logic [3:0]        DABBLE_ADD = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOAD,
        ST_EMIT
    } btda_state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit_load;
    } btda_ctrl_t;

    function automatic logic [BCD_BITS-1:0] dabble_adjust(input logic [BCD_BITS-1:0] bcd);
        logic [BCD_BITS-1:0] res;
        logic [3:0]          nib;
        res = bcd;
        for (int i = 0; i < DIGITS; i++)
        begin
            nib = bcd[i*4 +: 4];
            if (nib >= DABBLE_MIN)
            begin
                res[i*4 +: 4] = nib + DABBLE_ADD;
            end
        end
        return res;
    endfunction

endpackage

// ----- src/binary_to_decimal_ascii_top.sv -----
// binary to decimal ascii converter
//
// command channel: value is taken at a rising edge where start is high and
// busy is low. busy stays high until the last digit of that value is out.
// result channel: one decimal digit per beat, most significant first, no
// leading zeros; a zero value gives the single digit '0'. digit_strobe marks
// each beat for exactly one cycle, digit_char holds the ascii code and
// last_digit flags the final digit. the receiver cannot stall, so every
// strobed beat is taken in the cycle it is shown.
// operation: after the accepting edge the value is shifted through a
// shift-add-3 bcd register one bit per cycle, then a load step fills the
// digit shifter, then the digits are scanned one nibble per cycle. busy
// stays high through all three phases, and a new value can be accepted in
// the cycle after the last digit.
// reset: asynchronous, active low; returns to idle with no beat pending.
module binary_to_decimal_ascii_top
    import btda_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [PORT_BITS-1:0] value,
    output logic                digit_strobe,
    output logic [CHAR_W-1:0]   digit_char,
    output logic                last_digit
);

    btda_state_t          state_reg;
    btda_state_t          state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_next;
    btda_ctrl_t           ctrl;
    logic [BCD_BITS-1:0]  bcd;
    logic                 emit_done;
    logic                 accept;
    logic                 conv_last;

    assign accept    = start && !busy;
    assign conv_last = (bit_cnt_reg == BIT_CNT_W'(IN_BITS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy         = 1'b1;
        ctrl         = '0;
        bit_cnt_next = bit_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy         = 1'b0;
                ctrl.load    = start;
                bit_cnt_next = '0;
            end
            ST_CONV:
            begin
                ctrl.shift   = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
            end
            ST_LOAD:
            begin
                ctrl.emit_load = 1'b1;
            end
            ST_EMIT:
            begin
                ctrl = '0;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    btda_dabble u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .bin_in (value[IN_BITS-1:0]),
        .bcd    (bcd)
    );

    btda_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .bcd    (bcd),
        .strobe (digit_strobe),
        .digit  (digit_char),
        .last   (last_digit),
        .done   (emit_done)
    );

    // digits only go out while a value is in flight
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        digit_strobe |-> (busy && state_reg == ST_EMIT))
        else $error("digit beat outside emit phase");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && state_reg == ST_CONV))
        else $error("accepted value did not start conversion");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        last_digit |=> (!busy && !digit_strobe))
        else $error("beat or busy after last digit");

    a_emit_ends_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && emit_done) |-> last_digit)
        else $error("emit phase ended without a last digit");

endmodule

// ----- src/btda_dabble.sv -----
module btda_dabble
    import btda_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  btda_ctrl_t          ctrl,
    input  logic [IN_BITS-1:0]  bin_in,
    output logic [BCD_BITS-1:0] bcd
);

    logic [IN_BITS-1:0]  bin_reg;
    logic [IN_BITS-1:0]  bin_next;
    logic [BCD_BITS-1:0] bcd_reg;
    logic [BCD_BITS-1:0] bcd_next;
    logic [BCD_BITS-1:0] bcd_adj;

    assign bcd_adj = dabble_adjust(bcd_reg);

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.load)
        begin
            bin_next = bin_in;
            bcd_next = '0;
        end
        else if (ctrl.shift)
        begin
            // shift-add-3, one binary bit per cycle
            bin_next = {bin_reg[IN_BITS-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_BITS-2:0], bin_reg[IN_BITS-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg <= '0;
            bcd_reg <= '0;
        end
        else
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign bcd = bcd_reg;

endmodule

// ----- src/btda_emit.sv -----
module btda_emit
    import btda_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  btda_ctrl_t          ctrl,
    input  logic [BCD_BITS-1:0] bcd,
    output logic                strobe,
    output logic [CHAR_W-1:0]   digit,
    output logic                last,
    output logic                done
);

    logic [BCD_BITS-1:0]  shift_reg;
    logic [BCD_BITS-1:0]  shift_next;
    logic [DIG_CNT_W-1:0] cnt_reg;
    logic [DIG_CNT_W-1:0] cnt_next;
    logic                 active_reg;
    logic                 active_next;
    logic                 started_reg;
    logic                 started_next;
    logic [3:0]           top_nib;
    logic                 is_last;

    assign top_nib = shift_reg[BCD_BITS-1 -: 4];
    assign is_last = (cnt_reg == '0);

    // leading zeros are skipped, the final digit always goes out
    assign strobe = active_reg && (started_reg || (top_nib != 4'd0) || is_last);
    assign digit  = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, top_nib};
    assign last   = strobe && is_last;
    assign done   = active_reg && is_last;

    always_comb
    begin
        shift_next   = shift_reg;
        cnt_next     = cnt_reg;
        active_next  = active_reg;
        started_next = started_reg;
        if (ctrl.emit_load)
        begin
            shift_next   = bcd;
            cnt_next     = DIG_CNT_W'(DIGITS - 1);
            active_next  = 1'b1;
            started_next = 1'b0;
        end
        else if (active_reg)
        begin
            shift_next   = {shift_reg[BCD_BITS-5:0], 4'd0};
            cnt_next     = cnt_reg - 1'b1;
            started_next = strobe;
            if (is_last)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            active_reg  <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            active_reg  <= active_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import btda_pkg::*;

    localparam int NUM_RANDOM     = 260;
    localparam int NUM_CALM       = 60;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_beat_t;

    class digit_scoreboard;
        digit_beat_t pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // expected digits of one accepted value, most significant first
        function void note_value(logic [PORT_BITS-1:0] v);
            logic [63:0] mask;
            logic [63:0] rest;
            logic [3:0]  rev[$];
            digit_beat_t beat;
            mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
            rest = 64'(v) & mask;
            if (rest == 64'd0)
            begin
                beat.ch   = ASCII_ZERO;
                beat.last = 1'b1;
                pending.push_back(beat);
                return;
            end
            while (rest != 64'd0)
            begin
                rev.push_back(4'(rest % 64'd10));
                rest = rest / 64'd10;
            end
            for (int k = rev.size() - 1; k >= 0; k--)
            begin
                beat.ch   = ASCII_ZERO + CHAR_W'(rev[k]);
                beat.last = (k == 0);
                pending.push_back(beat);
            end
        endfunction

        function void check_beat(logic [CHAR_W-1:0] ch, logic last);
            digit_beat_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected digit beat: digit_char=%0d last_digit=%0b", ch, last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (ch !== want.ch)
            begin
                $error("digit_char: expected %0d, actual %0d", want.ch, ch);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_digit: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [PORT_BITS-1:0] value = '0;
    logic                 busy;
    logic                 digit_strobe;
    logic [CHAR_W-1:0]    digit_char;
    logic                 last_digit;

    digit_scoreboard sb = new();
    int              quiet_cycles = 0;

    logic [31:0] directed_values [20] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
        32'd999999999, 32'd1000000000, 32'd1000000001, 32'd2147483647,
        32'd2147483648, 32'd4000000000, 32'd4294967294, 32'd4294967295,
        32'h55555555, 32'hAAAAAAAA, 32'd123456789, 32'd1234567890
    };

    binary_to_decimal_ascii_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .digit_strobe (digit_strobe),
        .digit_char   (digit_char),
        .last_digit   (last_digit)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_value(value);
            end
            if (digit_strobe)
            begin
                sb.check_beat(digit_char, last_digit);
            end
            if ((start && !busy) || digit_strobe)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // value with a random digit count, or zero, or a fully random word
    function automatic logic [31:0] pick_value();
        int          sel;
        int          n;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] span;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            return 32'd0;
        end
        if (sel <= 3)
        begin
            return $urandom;
        end
        n  = $urandom_range(1, 10);
        lo = 64'd1;
        for (int i = 1; i < n; i++)
        begin
            lo = lo * 64'd10;
        end
        hi = lo * 64'd10 - 64'd1;
        if (n == 1)
        begin
            lo = 64'd0;
        end
        if (hi > 64'hFFFF_FFFF)
        begin
            hi = 64'hFFFF_FFFF;
        end
        span = hi - lo + 64'd1;
        return 32'(lo + ({$urandom, $urandom} % span));
    endfunction

    // one beat on the command side, after an optional idle burst
    task automatic send_value(input logic [31:0] v, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            value <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 4)
        begin
            return $urandom_range(1, 18);
        end
        return 0;
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_values[i])
        begin
            send_value(directed_values[i], pick_gap());
        end
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            send_value(pick_value(), (i < NUM_RANDOM - NUM_CALM) ? pick_gap() : 0);
        end
        start <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $error("%0d expected digit beats never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
